// ----- design/dbs_pkg.sv -----
// shared types and constants for the decimated bin sum / clamp / average block
// no dependencies
package dbs_pkg;

   localparam int MAX_POINTS  = 1024;
   localparam int PT_W        = $clog2(MAX_POINTS);
   localparam int NP_W        = 11;
   localparam int MAX_BATCHES = 64;
   localparam int BATCH_W     = 6;
   localparam int NB_W        = 7;
   localparam int SMP_W       = 32;
   localparam int ACC_W       = 40;
   localparam int AVG_W       = 27;
   localparam int OUT_W       = 18;
   localparam int LEN_W       = 11;
   localparam int MAG_W       = 27;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_POINTS  = 3'd0,
      REG_NUM_BATCHES = 3'd1,
      REG_ROW_WIDTH   = 3'd2,
      REG_DECIMATION  = 3'd3,
      REG_NORM_GAIN   = 3'd4,
      REG_AVG_LENGTH  = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [NP_W-1:0] num_points;
      logic [NB_W-1:0] num_batches;
      logic [15:0]     row_width;
      logic [7:0]      decimation;
      logic [31:0]     norm_gain;
      logic [LEN_W-1:0] avg_length;
   } cfg_type;

   // one selected sample on its way to the back end
   typedef struct packed {
      logic signed [SMP_W-1:0] sample;
      logic [PT_W-1:0]         point;
      logic                    first;
      logic                    last;
      logic                    done;
   } item_type;

endpackage

// ----- design/dbs_req_if.sv -----
// request channel: one signed Q16.16 sample
// depends on dbs_pkg
interface dbs_req_if import dbs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample;
   modport source (output valid, sample, input ready);
   modport sink (input valid, sample, output ready);
endinterface

// ----- design/dbs_rsp_if.sv -----
// response channel: point index, averaged amplitude, frame end flag
// depends on dbs_pkg
interface dbs_rsp_if import dbs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [PT_W-1:0]         point_index;
   logic signed [OUT_W-1:0] average_value;
   logic                    frame_done;
   modport source (output valid, point_index, average_value, frame_done, input ready);
   modport sink (input valid, point_index, average_value, frame_done, output ready);
endinterface

// ----- design/dbs_csr_if.sv -----
// register write channel: index and data
// depends on dbs_pkg
interface dbs_csr_if import dbs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- design/dbs_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module dbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/dbs_front.sv -----
// front end: column, stride, point and batch counters; passes selected samples on
// depends on dbs_pkg, dbs_req_if
module dbs_front import dbs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      enable,
   dbs_req_if.sink   req_if,
   input  logic      full,
   output logic      push,
   output item_type  item
);
   logic [15:0]        col_ff, col_in;
   logic [7:0]         stride_ff, stride_in;
   logic [NP_W-1:0]    point_ff, point_in;
   logic [BATCH_W-1:0] batch_ff, batch_in;

   logic [NP_W-1:0] np;
   logic [NB_W-1:0] nb;
   logic [15:0]     rw;
   logic [7:0]      dec;
   logic            accept, last_batch, row_end, selected, done;

   always_comb begin
      np  = (cfg.num_points > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : cfg.num_points;
      nb  = (cfg.num_batches == '0) ? NB_W'(1) :
            ((cfg.num_batches > NB_W'(MAX_BATCHES)) ? NB_W'(MAX_BATCHES) : cfg.num_batches);
      rw  = (cfg.row_width == '0) ? 16'd1 : cfg.row_width;
      dec = (cfg.decimation == '0) ? 8'd1 : cfg.decimation;

      req_if.ready = enable && !full;
      accept       = req_if.valid && req_if.ready;

      last_batch = ({1'b0, batch_ff} + NB_W'(1)) >= nb;
      row_end    = ({1'b0, col_ff} + 17'd1) >= {1'b0, rw};
      selected   = (stride_ff == '0) && (point_ff < np);
      done       = (({1'b0, point_ff} + 12'd1) >= {1'b0, np}) ||
                   (({1'b0, col_ff} + {9'b0, dec}) >= {1'b0, rw});

      push       = accept && selected;
      item.sample = req_if.sample;
      item.point  = point_ff[PT_W-1:0];
      item.first  = (batch_ff == '0);
      item.last   = last_batch;
      item.done   = done;

      col_in    = col_ff;
      stride_in = stride_ff;
      point_in  = point_ff;
      batch_in  = batch_ff;
      if (accept) begin
         if (row_end) begin
            col_in    = '0;
            stride_in = '0;
            point_in  = '0;
            batch_in  = last_batch ? '0 : batch_ff + BATCH_W'(1);
         end else begin
            col_in    = col_ff + 16'd1;
            point_in  = selected ? point_ff + NP_W'(1) : point_ff;
            stride_in = (({1'b0, stride_ff} + 9'd1) >= {1'b0, dec}) ? '0 : stride_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         stride_ff <= '0;
         point_ff  <= '0;
         batch_ff  <= '0;
      end else begin
         col_ff    <= col_in;
         stride_ff <= stride_in;
         point_ff  <= point_in;
         batch_ff  <= batch_in;
      end
   end
endmodule

// ----- design/dbs_queue.sv -----
// short fifo between front and back end
// depends on dbs_pkg
module dbs_queue import dbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type head,
   output logic     empty
);
   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      empty = (count_ff == '0);
      head  = mem_ff[rd_ptr_ff];
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end
endmodule

// ----- design/dbs_back.sv -----
// back end: accumulate per point, scale, clamp, divide and update the average
// depends on dbs_pkg, dbs_ram, dbs_rsp_if
module dbs_back import dbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  item_type head,
   input  logic     empty,
   output logic     pop,
   output logic     clear_busy,
   dbs_rsp_if.source rsp_if
);
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_ACC  = 7'b0000010,
      ST_MHI  = 7'b0000100,
      ST_MLO  = 7'b0001000,
      ST_AMP  = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   item_type  cur_ff, cur_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [AVG_W-1:0] avg_ff, avg_in;
   logic [55:0]      hi_ff, hi_in, lo_ff, lo_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [9:0]       rem_ff, rem_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [PT_W:0]    clr_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PT_W-1:0]         rsp_point_ff, rsp_point_in;
   logic signed [OUT_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic                    rsp_done_ff, rsp_done_in;

   logic             acc_we, avg_we;
   logic [PT_W-1:0]  rd_addr, avg_waddr;
   logic [ACC_W-1:0] acc_rd, acc_wdata;
   logic [AVG_W-1:0] avg_rd, avg_wdata;

   logic [LEN_W-1:0]        len;
   logic signed [ACC_W:0]   sum;
   logic [57:0]             total;
   logic [33:0]             q;
   logic signed [OUT_W-1:0] amp;
   logic signed [27:0]      diff, quot, avg_sum, rnd;
   logic [10:0]             rem_sh;
   logic                    ge, slot_free;

   dbs_ram #(.WIDTH(ACC_W), .DEPTH(MAX_POINTS)) u_acc_ram (
      .clock(clock), .wr_en(acc_we), .wr_addr(cur_ff.point), .wr_data(acc_wdata),
      .rd_addr(rd_addr), .rd_data(acc_rd)
   );

   dbs_ram #(.WIDTH(AVG_W), .DEPTH(MAX_POINTS)) u_avg_ram (
      .clock(clock), .wr_en(avg_we), .wr_addr(avg_waddr), .wr_data(avg_wdata),
      .rd_addr(rd_addr), .rd_data(avg_rd)
   );

   always_comb begin
      len        = (cfg.avg_length == '0) ? LEN_W'(1) : cfg.avg_length;
      clear_busy = !clr_ff[PT_W];
      slot_free  = !rsp_valid_ff || rsp_if.ready;

      state_in = state_ff;
      cur_in   = cur_ff;
      acc_in   = acc_ff;
      avg_in   = avg_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      pop      = 1'b0;
      rd_addr  = head.point;
      acc_we   = 1'b0;
      avg_we   = clear_busy;
      avg_waddr = clr_ff[PT_W-1:0];
      avg_wdata = '0;

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_point_in = rsp_point_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_done_in  = rsp_done_ff;

      // saturating accumulate
      sum = {acc_rd[ACC_W-1], acc_rd} + (ACC_W+1)'(cur_ff.sample);
      if (cur_ff.first) begin
         acc_wdata = ACC_W'(cur_ff.sample);
      end else if (sum[ACC_W] != sum[ACC_W-1]) begin
         acc_wdata = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_wdata = sum[ACC_W-1:0];
      end

      // gain scale, round, subtract one, clamp
      total = {2'b0, hi_ff[39:0], 16'b0} + {2'b0, lo_ff} + 58'(1 << 23);
      q     = total[57:24];
      if (acc_ff[ACC_W-1] || (acc_ff == '0)) begin
         amp = -18'sd65536;
      end else if ((|hi_ff[55:40]) || (q >= 34'd131072)) begin
         amp = 18'sd65536;
      end else begin
         amp = $signed({1'b0, q[16:0]}) - 18'sd65536;
      end
      diff = $signed({amp[OUT_W-1], amp, 9'b0}) - 28'(avg_ff);

      // restoring divide, one quotient bit per cycle
      rem_sh = {rem_ff, quo_ff[MAG_W-1]};
      ge     = rem_sh >= len;

      quot    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      avg_sum = 28'(avg_ff) + quot;
      rnd     = avg_sum + 28'sd256;

      case (state_ff)
         ST_IDLE: begin
            if (!empty && !clear_busy) begin
               pop      = 1'b1;
               cur_in   = head;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            acc_we   = 1'b1;
            acc_in   = acc_wdata;
            avg_in   = avg_rd;
            state_in = cur_ff.last ? ST_MHI : ST_IDLE;
         end
         ST_MHI: begin
            hi_in    = acc_ff[ACC_W-1:0] * cfg.norm_gain[31:16];
            state_in = ST_MLO;
         end
         ST_MLO: begin
            lo_in    = acc_ff[ACC_W-1:0] * cfg.norm_gain[15:0];
            state_in = ST_AMP;
         end
         ST_AMP: begin
            neg_in   = diff[27];
            quo_in   = diff[27] ? MAG_W'(-diff) : diff[MAG_W-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? 10'(rem_sh - len) : rem_sh[9:0];
            quo_in = {quo_ff[MAG_W-2:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(MAG_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               avg_we       = 1'b1;
               avg_waddr    = cur_ff.point;
               avg_wdata    = avg_sum[AVG_W-1:0];
               rsp_valid_in = 1'b1;
               rsp_point_in = cur_ff.point;
               rsp_avg_in   = rnd[26:9];
               rsp_done_in  = cur_ff.done;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_if.valid         = rsp_valid_ff;
      rsp_if.point_index   = rsp_point_ff;
      rsp_if.average_value = rsp_avg_ff;
      rsp_if.frame_done    = rsp_done_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      acc_ff       <= acc_in;
      avg_ff       <= avg_in;
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      rsp_point_ff <= rsp_point_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_done_ff  <= rsp_done_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear_busy) clr_ff <= clr_ff + (PT_W+1)'(1);
      end
   end
endmodule

// ----- design/decimated_bin_sum_clamp_ema_core.sv -----
// top level: register file, front end, queue and back end
// depends on dbs_pkg, dbs_*_if, dbs_front, dbs_queue, dbs_back
//
// channel  dir  payload                                       accepted when
// req_if   in   sample (s32 Q16.16)                           valid & ready
// rsp_if   out  point_index, average_value (s18 Q1.16), done  valid & ready
// csr_if   in   index (3b), data (32b)                        valid & ready
//
// a request is accepted combinationally while the queue has room; only
// selected columns enter the queue. the back end takes a selected sample of
// an early row through its pop and accumulate steps; one of the last row goes
// on through gain multiply, clamp, the bit-serial divider and output steps.
// after reset all 1024 entries of the average memory are cleared; no request
// is taken then. a stalled response holds the back end in its output step.
module decimated_bin_sum_clamp_ema_core import dbs_pkg::*; (
   input logic       clock,
   input logic       reset,
   dbs_req_if.sink   req_if,
   dbs_rsp_if.source rsp_if,
   dbs_csr_if.sink   csr_if
);
   cfg_type  cfg_ff, cfg_in;
   item_type push_item, head;
   logic     push, full, pop, empty, clear_busy;

   always_comb begin
      csr_if.ready = 1'b1;
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            REG_NUM_POINTS:  cfg_in.num_points  = csr_if.data[NP_W-1:0];
            REG_NUM_BATCHES: cfg_in.num_batches = csr_if.data[NB_W-1:0];
            REG_ROW_WIDTH:   cfg_in.row_width   = csr_if.data[15:0];
            REG_DECIMATION:  cfg_in.decimation  = csr_if.data[7:0];
            REG_NORM_GAIN:   cfg_in.norm_gain   = csr_if.data;
            REG_AVG_LENGTH:  cfg_in.avg_length  = csr_if.data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_points  <= NP_W'(1024);
         cfg_ff.num_batches <= NB_W'(1);
         cfg_ff.row_width   <= 16'd1024;
         cfg_ff.decimation  <= 8'd1;
         cfg_ff.norm_gain   <= 32'd16777216;
         cfg_ff.avg_length  <= LEN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dbs_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .enable(!clear_busy),
      .req_if(req_if), .full(full), .push(push), .item(push_item)
   );

   dbs_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item), .full(full),
      .pop(pop), .head(head), .empty(empty)
   );

   dbs_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .head(head), .empty(empty),
      .pop(pop), .clear_busy(clear_busy), .rsp_if(rsp_if)
   );
endmodule
